@@ sv/l2c_pkg.sv @@
// ----------------------------------------------------------------------------
// l2c_pkg
// Shared widths, register indexes, reset values and types of the LBA to
// CHS mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package l2c_pkg;

  localparam int unsigned SECTOR_BYTES    = 512;
  localparam int unsigned DRIVE_UNITS_DEF = 4;

  localparam int unsigned UNIT_W     = 2;
  localparam int unsigned LBA_W      = 32;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned ADDR_W     = 20;
  localparam int unsigned LOW_W      = 16;
  localparam int unsigned HEADS_W    = 8;
  localparam int unsigned SPT_W      = 6;
  localparam int unsigned PC_W       = HEADS_W + SPT_W;
  localparam int unsigned CYL_W      = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned DMA_W      = LOW_W + CNT_W;

  localparam logic [HEADS_W-1:0] HEADS_RST = 8'd2;
  localparam logic [SPT_W-1:0]   SPT_RST   = 6'd9;

  localparam int unsigned CFG_HEADS_BASE = 0;
  localparam int unsigned CFG_SPT_BASE   = 4;

  localparam int unsigned DIV_STEP    = 4;
  localparam int unsigned CYL_STAGES  = LBA_W / DIV_STEP;
  localparam int unsigned HEAD_STAGES = HEADS_W / DIV_STEP;
  localparam int unsigned PIPE_STAGES = CYL_STAGES + HEAD_STAGES;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [LBA_W-1:0] lba;
    logic [CNT_W-1:0] count;
    logic [LOW_W-1:0] dma_rem;
    logic [SPT_W-1:0] spt;
    logic [PC_W-1:0]  per_cyl;
  } l2c_req_t;

  typedef struct packed {
    logic [LBA_W-1:0]   dq;
    logic [PC_W-1:0]    rem;
    logic [PC_W-1:0]    per_cyl;
    logic [SPT_W-1:0]   spt;
    logic [CNT_W-1:0]   count;
    logic [LOW_W-1:0]   dma_rem;
    logic [CNT_W-1:0]   dma_q;
    logic               dma_sat;
    logic [SPT_W-1:0]   hrem;
    logic [HEADS_W-1:0] hdq;
  } l2c_work_t;

  typedef struct packed {
    logic [CYL_W-1:0]   cylinder;
    logic [SPT_W-1:0]   sector_number;
    logic [HEADS_W-1:0] head_number;
    logic [CNT_W-1:0]   allowed_count;
    logic               cylinder_overflow;
  } l2c_res_t;

endpackage

`default_nettype wire

@@ sv/lba_to_chs_mapper_core.sv @@
// ----------------------------------------------------------------------------
// lba_to_chs_mapper_core
// Maps a logical sector request to cylinder, head and sector, limiting the
// count at the 64 KiB DMA boundary and at the end of the cylinder.
//
//   channel  direction  handshake                  word
//   in       sink       in_valid_i / in_stall_o    unit, lba, count, address
//   out      source     out_valid_o / out_stall_i  cyl, sector, head, count, ovf
//   cfg      sink       cfg_valid_i / cfg_ready_o  register index, data
//
// One word per cycle while the output is not stalled; a request passes the
// 2-entry request queue, the 10-stage divider pipeline at 4 quotient bits a
// stage and the result register.
// Reset clears the queue, the pipeline valids and loads the default geometry.
// An output stall holds the whole pipeline while the output is valid; the
// input stalls once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module lba_to_chs_mapper_core #(
  parameter int unsigned DRIVE_UNITS = l2c_pkg::DRIVE_UNITS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire [l2c_pkg::UNIT_W-1:0]      drive_unit_i,
  input  wire [l2c_pkg::LBA_W-1:0]       start_lba_i,
  input  wire [l2c_pkg::CNT_W-1:0]       sector_count_i,
  input  wire [l2c_pkg::ADDR_W-1:0]      buffer_address_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic [l2c_pkg::CYL_W-1:0]      cylinder_o,
  output logic [l2c_pkg::SPT_W-1:0]      sector_number_o,
  output logic [l2c_pkg::HEADS_W-1:0]    head_number_o,
  output logic [l2c_pkg::CNT_W-1:0]      allowed_count_o,
  output logic                           cylinder_overflow_o,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [l2c_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [l2c_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  logic              push;
  logic              full;
  logic              pop;
  logic              q_vld;
  l2c_pkg::l2c_req_t req;
  l2c_pkg::l2c_req_t q_data;
  l2c_pkg::l2c_res_t res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;

  l2c_front #(
    .DRIVE_UNITS (DRIVE_UNITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .full_i           (full),
    .drive_unit_i     (drive_unit_i),
    .start_lba_i      (start_lba_i),
    .sector_count_i   (sector_count_i),
    .buffer_address_i (buffer_address_i),
    .push_o           (push),
    .req_o            (req)
  );

  l2c_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (req),
    .pop_i       (pop),
    .full_o      (full),
    .vld_o       (q_vld),
    .data_o      (q_data)
  );

  l2c_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_vld_i     (q_vld),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign cylinder_o          = res.cylinder;
  assign sector_number_o     = res.sector_number;
  assign head_number_o       = res.head_number;
  assign allowed_count_o     = res.allowed_count;
  assign cylinder_overflow_o = res.cylinder_overflow;

endmodule

`default_nettype wire

@@ sv/l2c_front.sv @@
// ----------------------------------------------------------------------------
// l2c_front
// Geometry registers and request intake: selects the unit geometry, fixes
// zero values, forms sectors per cylinder and the DMA window remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module l2c_front #(
  parameter int unsigned DRIVE_UNITS = l2c_pkg::DRIVE_UNITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_valid_i,
  input  wire [l2c_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire [l2c_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire                               in_valid_i,
  input  wire                               full_i,
  input  wire [l2c_pkg::UNIT_W-1:0]         drive_unit_i,
  input  wire [l2c_pkg::LBA_W-1:0]          start_lba_i,
  input  wire [l2c_pkg::CNT_W-1:0]          sector_count_i,
  input  wire [l2c_pkg::ADDR_W-1:0]         buffer_address_i,
  output logic                              push_o,
  output l2c_pkg::l2c_req_t                 req_o
);

  logic [l2c_pkg::HEADS_W-1:0] heads_q [DRIVE_UNITS];
  logic [l2c_pkg::SPT_W-1:0]   spt_q   [DRIVE_UNITS];
  logic [l2c_pkg::HEADS_W-1:0] heads_sel;
  logic [l2c_pkg::SPT_W-1:0]   spt_sel;
  logic [l2c_pkg::HEADS_W-1:0] heads_fix;
  logic [l2c_pkg::SPT_W-1:0]   spt_fix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int u = 0; u < DRIVE_UNITS; u++) begin
        heads_q[u] <= l2c_pkg::HEADS_RST;
        spt_q[u]   <= l2c_pkg::SPT_RST;
      end
    end else if (cfg_valid_i) begin
      for (int u = 0; u < DRIVE_UNITS; u++) begin
        if (cfg_index_i == l2c_pkg::CFG_IDX_W'(l2c_pkg::CFG_HEADS_BASE + u)) begin
          heads_q[u] <= cfg_wdata_i[l2c_pkg::HEADS_W-1:0];
        end
        if (cfg_index_i == l2c_pkg::CFG_IDX_W'(l2c_pkg::CFG_SPT_BASE + u)) begin
          spt_q[u] <= cfg_wdata_i[l2c_pkg::SPT_W-1:0];
        end
      end
    end
  end

  always_comb begin
    heads_sel = heads_q[0];
    spt_sel   = spt_q[0];
    for (int u = 1; u < DRIVE_UNITS; u++) begin
      if (drive_unit_i == l2c_pkg::UNIT_W'(u)) begin
        heads_sel = heads_q[u];
        spt_sel   = spt_q[u];
      end
    end
    heads_fix = (heads_sel == '0) ? l2c_pkg::HEADS_W'(1) : heads_sel;
    spt_fix   = (spt_sel == '0) ? l2c_pkg::SPT_W'(1) : spt_sel;
  end

  assign push_o          = in_valid_i && !full_i;
  assign req_o.lba       = start_lba_i;
  assign req_o.count     = sector_count_i;
  assign req_o.dma_rem   = ~buffer_address_i[l2c_pkg::LOW_W-1:0];
  assign req_o.spt       = spt_fix;
  assign req_o.per_cyl   = l2c_pkg::PC_W'(heads_fix) * l2c_pkg::PC_W'(spt_fix);

endmodule

`default_nettype wire

@@ sv/l2c_queue.sv @@
// ----------------------------------------------------------------------------
// l2c_queue
// Short request queue between intake and the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module l2c_queue (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  l2c_pkg::l2c_req_t  push_data_i,
  input  wire                pop_i,
  output logic               full_o,
  output logic               vld_o,
  output l2c_pkg::l2c_req_t  data_o
);

  localparam int unsigned DEPTH = l2c_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  l2c_pkg::l2c_req_t mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              do_pop;

  assign full_o = (fill_q == CNT_W'(DEPTH));
  assign vld_o  = (fill_q != '0);
  assign data_o = mem_q[rd_ptr_q];
  assign do_pop = pop_i && vld_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/l2c_back.sv @@
// ----------------------------------------------------------------------------
// l2c_back
// Divider pipeline: cylinder and in-cylinder offset at four quotient bits a
// stage, DMA limit in the first stages, then head and sector, then limits.
// ----------------------------------------------------------------------------
`default_nettype none

module l2c_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                q_vld_i,
  input  l2c_pkg::l2c_req_t  q_data_i,
  output logic               pop_o,
  input  wire                out_stall_i,
  output logic               out_valid_o,
  output l2c_pkg::l2c_res_t  res_o
);

  localparam int unsigned NSTG = l2c_pkg::PIPE_STAGES;

  l2c_pkg::l2c_work_t stg_in  [NSTG];
  l2c_pkg::l2c_work_t stg_out [NSTG];
  l2c_pkg::l2c_work_t st_q    [NSTG];
  logic               vld_q   [NSTG];
  logic               adv;
  logic               out_vld_q;
  l2c_pkg::l2c_res_t  res_q, res_d;

  assign adv   = !out_vld_q || !out_stall_i;
  assign pop_o = adv;

  always_comb begin
    stg_in[0]         = '0;
    stg_in[0].dq      = q_data_i.lba;
    stg_in[0].per_cyl = q_data_i.per_cyl;
    stg_in[0].spt     = q_data_i.spt;
    stg_in[0].count   = q_data_i.count;
    stg_in[0].dma_rem = q_data_i.dma_rem;
    stg_in[0].dma_sat = (l2c_pkg::DMA_W'(q_data_i.dma_rem) >=
                         (l2c_pkg::DMA_W'(l2c_pkg::SECTOR_BYTES) << l2c_pkg::CNT_W));
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    if (s > 0) begin : g_link
      assign stg_in[s] = st_q[s-1];
    end

    always_comb begin
      l2c_pkg::l2c_work_t          w;
      logic [l2c_pkg::PC_W:0]      r_cyl;
      logic [l2c_pkg::SPT_W:0]     r_hd;
      logic [l2c_pkg::DMA_W-1:0]   d_rem;
      logic [l2c_pkg::DMA_W-1:0]   d_div;
      logic                        ge;
      w     = stg_in[s];
      r_cyl = '0;
      r_hd  = '0;
      d_rem = '0;
      d_div = '0;
      ge    = 1'b0;
      if (s < l2c_pkg::CYL_STAGES) begin
        for (int j = 0; j < l2c_pkg::DIV_STEP; j++) begin
          r_cyl = {w.rem, w.dq[l2c_pkg::LBA_W-1]};
          ge    = (r_cyl >= {1'b0, w.per_cyl});
          w.dq  = {w.dq[l2c_pkg::LBA_W-2:0], ge};
          w.rem = ge ? l2c_pkg::PC_W'(r_cyl - {1'b0, w.per_cyl})
                     : r_cyl[l2c_pkg::PC_W-1:0];
          if (s * l2c_pkg::DIV_STEP + j < l2c_pkg::CNT_W) begin
            d_rem = l2c_pkg::DMA_W'(w.dma_rem);
            d_div = l2c_pkg::DMA_W'(l2c_pkg::SECTOR_BYTES)
                    << (l2c_pkg::CNT_W - 1 - (s * l2c_pkg::DIV_STEP + j));
            ge    = (d_rem >= d_div);
            w.dma_q = {w.dma_q[l2c_pkg::CNT_W-2:0], ge};
            if (ge) begin
              w.dma_rem = l2c_pkg::LOW_W'(d_rem - d_div);
            end
          end
        end
      end else begin
        if (s == l2c_pkg::CYL_STAGES) begin
          w.hrem = w.rem[l2c_pkg::PC_W-1:l2c_pkg::HEADS_W];
          w.hdq  = w.rem[l2c_pkg::HEADS_W-1:0];
        end
        for (int j = 0; j < l2c_pkg::DIV_STEP; j++) begin
          r_hd   = {w.hrem, w.hdq[l2c_pkg::HEADS_W-1]};
          ge     = (r_hd >= {1'b0, w.spt});
          w.hdq  = {w.hdq[l2c_pkg::HEADS_W-2:0], ge};
          w.hrem = ge ? l2c_pkg::SPT_W'(r_hd - {1'b0, w.spt})
                      : r_hd[l2c_pkg::SPT_W-1:0];
        end
      end
      stg_out[s] = w;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv) begin
        vld_q[s] <= (s == 0) ? q_vld_i : vld_q[(s > 0) ? s - 1 : 0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[s] <= stg_out[s];
      end
    end
  end

  always_comb begin
    l2c_pkg::l2c_work_t        f;
    logic [l2c_pkg::CNT_W-1:0] c_dma;
    logic [l2c_pkg::PC_W:0]    c_end;
    f     = st_q[NSTG-1];
    c_dma = (f.dma_sat || (f.count <= f.dma_q)) ? f.count : f.dma_q;
    c_end = {1'b0, f.rem} + (l2c_pkg::PC_W + 1)'(c_dma);
    res_d.cylinder          = f.dq[l2c_pkg::CYL_W-1:0];
    res_d.cylinder_overflow = |f.dq[l2c_pkg::LBA_W-1:l2c_pkg::CYL_W];
    res_d.head_number       = f.hdq;
    res_d.sector_number     = f.hrem + l2c_pkg::SPT_W'(1);
    res_d.allowed_count     = (c_end > {1'b0, f.per_cyl})
                              ? l2c_pkg::CNT_W'(f.per_cyl - f.rem) : c_dma;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
